### hw/rtl/ppsp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the periodic pulse start planner
// no dependencies

package ppsp_pkg;

    localparam logic [63:0] NS_PER_SEC    = 64'd1000000000;
    localparam logic [31:0] NS_PER_2SEC   = 32'd2000000000;
    localparam logic [63:0] SEC32_LIMIT   = 64'd4294967296000000000;
    localparam logic [31:0] GUARD_RESET   = 32'd1000000;
    localparam int          QUEUE_DEPTH   = 2;
    // floor(2^62 / 1e9) minus 2^32, reciprocal for the seconds split
    localparam logic [28:0] SPLIT_RECIP   = 29'd316718722;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_UPDATE = 2'd1,
        ST_INVALID   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // one classified request as it travels from the front to the back
    typedef struct packed {
        status_t     pre_status;
        logic        absolute;
        logic [63:0] earliest;
        logic [63:0] period;
        logic [63:0] pulse;
        logic [63:0] phase;
        logic [31:0] abs_sec;
        logic [29:0] abs_sub;
    } req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] remainder;
    } div_stat_t;

endpackage

### hw/rtl/ppsp_front.sv
`timescale 1ns / 1ps
// front part: classifies one request and forms the queue entry
// depends on ppsp_pkg

module ppsp_front (
    input  logic [63:0]   current_time_ns,
    input  logic [63:0]   period_ns,
    input  logic [63:0]   pulse_ns,
    input  logic [63:0]   phase_ns,
    input  logic          enable_request,
    input  logic          absolute_mode,
    input  logic [31:0]   abs_start_sec,
    input  logic [31:0]   abs_start_subsec,
    input  logic [31:0]   start_guard_ns,
    output ppsp_pkg::req_t entry
);

    logic [64:0] earliest_sum;
    logic        bad_abs;
    logic        update;
    logic        bad_timing;

    // guard sum with carry out for overflow
    assign earliest_sum = {1'b0, current_time_ns} + {33'b0, start_guard_ns};

    assign bad_abs = absolute_mode &&
                     ((abs_start_subsec >= 32'(ppsp_pkg::NS_PER_SEC)) || (phase_ns != 64'd0));
    assign update  = absolute_mode || enable_request || (period_ns != 64'd0) ||
                     (pulse_ns != 64'd0) || (phase_ns != 64'd0);
    assign bad_timing = (period_ns < 64'd2) || (pulse_ns == 64'd0) ||
                        (pulse_ns >= period_ns) ||
                        (!absolute_mode && (phase_ns >= period_ns)) ||
                        (period_ns >= ppsp_pkg::SEC32_LIMIT);

    // checks in priority order
    always_comb begin
        entry.absolute = absolute_mode;
        entry.earliest = earliest_sum[63:0];
        entry.period   = period_ns;
        entry.pulse    = pulse_ns;
        entry.phase    = phase_ns;
        entry.abs_sec  = abs_start_sec;
        entry.abs_sub  = abs_start_subsec[29:0];
        if (bad_abs) begin
            entry.pre_status = ppsp_pkg::ST_INVALID;
        end else if (!update) begin
            entry.pre_status = ppsp_pkg::ST_NO_UPDATE;
        end else if (bad_timing) begin
            entry.pre_status = ppsp_pkg::ST_INVALID;
        end else if (earliest_sum[64]) begin
            entry.pre_status = ppsp_pkg::ST_OVERFLOW;
        end else begin
            entry.pre_status = ppsp_pkg::ST_OK;
        end
    end

endmodule

### hw/rtl/ppsp_queue.sv
`timescale 1ns / 1ps
// short request queue between front and back
// depends on ppsp_pkg

module ppsp_queue #(
    parameter int DEPTH = ppsp_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ppsp_pkg::req_t push_data,
    output logic           full,
    input  logic           pop,
    output ppsp_pkg::req_t pop_data,
    output logic           not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ppsp_pkg::req_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/ppsp_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
// depends on ppsp_pkg

module ppsp_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppsp_pkg::div_ctl_t  ctl,
    output ppsp_pkg::div_stat_t stat
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {rem_reg, dvd_reg[63]};
    assign diff  = trial - {1'b0, dsr_reg};

    // one shift-subtract step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg) begin
            if (!diff[64]) begin
                rem_next = diff[63:0];
                dvd_next = {dvd_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[63:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = ctl.dividend;
            rem_next  = '0;
            dsr_next  = ctl.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

endmodule

### hw/rtl/ppsp_back.sv
`timescale 1ns / 1ps
// back part: start time sequencer, split into seconds, result register
// depends on ppsp_pkg and ppsp_div

module ppsp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  ppsp_pkg::req_t q_data,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [31:0]    m_start_sec_out,
    output logic [29:0]    m_start_subsec_out,
    output logic [31:0]    m_period_sec_out,
    output logic [29:0]    m_period_subsec_out,
    output logic [31:0]    m_pulse_sec_out,
    output logic [29:0]    m_pulse_subsec_out
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_ABS   = 12'b0000_0000_0010,
        S_CHK   = 12'b0000_0000_0100,
        S_MOD   = 12'b0000_0000_1000,
        S_REL1  = 12'b0000_0001_0000,
        S_REL2  = 12'b0000_0010_0000,
        S_REL3  = 12'b0000_0100_0000,
        S_RANGE = 12'b0000_1000_0000,
        S_DIV_S = 12'b0001_0000_0000,
        S_DIV_P = 12'b0010_0000_0000,
        S_DIV_Q = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    ppsp_pkg::req_t      req_reg, req_next;
    ppsp_pkg::status_t   status_reg, status_next;
    logic                launched_reg, launched_next;
    logic [63:0]         start_reg, start_next;
    logic [63:0]         rem_reg, rem_next;
    logic [31:0]         ssec_reg, ssec_next;
    logic [29:0]         ssub_reg, ssub_next;
    logic [31:0]         psec_reg, psec_next;
    logic [29:0]         psub_reg, psub_next;
    logic [31:0]         wsec_reg, wsec_next;
    logic [29:0]         wsub_reg, wsub_next;

    logic [2:0]          sp_ph_reg, sp_ph_next;
    logic [60:0]         sp_p_reg, sp_p_next;
    logic [31:0]         sp_q_reg, sp_q_next;
    logic [61:0]         sp_m_reg, sp_m_next;
    logic [31:0]         sp_r_reg, sp_r_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          o_status_reg, o_status_next;
    logic [31:0]         o_ssec_reg, o_ssec_next;
    logic [29:0]         o_ssub_reg, o_ssub_next;
    logic [31:0]         o_psec_reg, o_psec_next;
    logic [29:0]         o_psub_reg, o_psub_next;
    logic [31:0]         o_wsec_reg, o_wsec_next;
    logic [29:0]         o_wsub_reg, o_wsub_next;

    ppsp_pkg::div_ctl_t  div_ctl;
    ppsp_pkg::div_stat_t div_stat;
    logic [61:0]         abs_prod;
    logic [63:0]         base;
    logic [64:0]         add_sum;
    logic [63:0]         add_op;
    logic                ok;
    logic [63:0]         split_src;
    logic [32:0]         sp_q_sum;
    logic [61:0]         sp_diff;
    logic [31:0]         sp_q_fix;
    logic [29:0]         sp_r_fix;

    ppsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .stat    (div_stat)
    );

    // absolute start in ns, one multiply-add
    assign abs_prod = req_reg.abs_sec * ppsp_pkg::NS_PER_SEC[29:0] + 62'(req_reg.abs_sub);

    // aligned boundary and the shared 64-bit adder with carry
    assign base = req_reg.earliest - rem_reg;
    always_comb begin
        case (state_reg)
            S_REL2:  add_op = req_reg.phase;
            default: add_op = req_reg.period;
        endcase
    end
    assign add_sum = (state_reg == S_REL1) ? ({1'b0, base} + {1'b0, add_op})
                                           : ({1'b0, start_reg} + {1'b0, add_op});

    // divider runs the period remainder only
    assign div_ctl.start    = (state_reg == S_MOD) && !launched_reg;
    assign div_ctl.dividend = req_reg.earliest;
    assign div_ctl.divisor  = req_reg.period;

    // operand of the seconds split, always below 2^62 here
    always_comb begin
        case (state_reg)
            S_DIV_P: split_src = req_reg.period;
            S_DIV_Q: split_src = req_reg.pulse;
            default: split_src = start_reg;
        endcase
    end

    // quotient estimate is at most two low, remainder fixed up by compare
    assign sp_q_sum = {1'b0, split_src[61:30]} + {4'b0, sp_p_reg[60:32]};
    assign sp_diff  = split_src[61:0] - sp_m_reg;
    always_comb begin
        if (sp_r_reg >= ppsp_pkg::NS_PER_2SEC) begin
            sp_q_fix = sp_q_reg + 32'd2;
            sp_r_fix = 30'(sp_r_reg - ppsp_pkg::NS_PER_2SEC);
        end else if (sp_r_reg >= ppsp_pkg::NS_PER_SEC[31:0]) begin
            sp_q_fix = sp_q_reg + 32'd1;
            sp_r_fix = 30'(sp_r_reg - ppsp_pkg::NS_PER_SEC[31:0]);
        end else begin
            sp_q_fix = sp_q_reg;
            sp_r_fix = sp_r_reg[29:0];
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        status_next   = status_reg;
        launched_next = launched_reg;
        start_next    = start_reg;
        rem_next      = rem_reg;
        ssec_next     = ssec_reg;
        ssub_next     = ssub_reg;
        psec_next     = psec_reg;
        psub_next     = psub_reg;
        wsec_next     = wsec_reg;
        wsub_next     = wsub_reg;
        sp_ph_next    = sp_ph_reg;
        sp_p_next     = sp_p_reg;
        sp_q_next     = sp_q_reg;
        sp_m_next     = sp_m_reg;
        sp_r_next     = sp_r_reg;
        q_pop         = 1'b0;

        out_valid_next = out_valid_reg;
        o_status_next  = o_status_reg;
        o_ssec_next    = o_ssec_reg;
        o_ssub_next    = o_ssub_reg;
        o_psec_next    = o_psec_reg;
        o_psub_next    = o_psub_reg;
        o_wsec_next    = o_wsec_reg;
        o_wsub_next    = o_wsub_reg;
        ok             = (status_reg == ppsp_pkg::ST_OK);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    req_next    = q_data;
                    status_next = q_data.pre_status;
                    if (q_data.pre_status != ppsp_pkg::ST_OK) begin
                        state_next = S_DONE;
                    end else if (q_data.absolute) begin
                        state_next = S_ABS;
                    end else begin
                        state_next = S_MOD;
                    end
                end
            end
            S_ABS: begin
                start_next = 64'(abs_prod);
                state_next = S_CHK;
            end
            S_CHK: begin
                if (start_reg <= req_reg.earliest) begin
                    status_next = ppsp_pkg::ST_INVALID;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_RANGE;
                end
            end
            S_MOD: begin
                if (!launched_reg) begin
                    launched_next = 1'b1;
                end else if (div_stat.done) begin
                    launched_next = 1'b0;
                    rem_next      = div_stat.remainder;
                    state_next    = S_REL1;
                end
            end
            S_REL1: begin
                if (rem_reg == 64'd0) begin
                    start_next = base;
                    state_next = S_REL2;
                end else if (add_sum[64]) begin
                    status_next = ppsp_pkg::ST_OVERFLOW;
                    state_next  = S_DONE;
                end else begin
                    start_next = add_sum[63:0];
                    state_next = S_REL2;
                end
            end
            S_REL2: begin
                if (add_sum[64]) begin
                    status_next = ppsp_pkg::ST_OVERFLOW;
                    state_next  = S_DONE;
                end else begin
                    start_next = add_sum[63:0];
                    state_next = S_REL3;
                end
            end
            S_REL3: begin
                if (start_reg > req_reg.earliest) begin
                    state_next = S_RANGE;
                end else if (add_sum[64]) begin
                    status_next = ppsp_pkg::ST_OVERFLOW;
                    state_next  = S_DONE;
                end else begin
                    start_next = add_sum[63:0];
                    state_next = S_RANGE;
                end
            end
            S_RANGE: begin
                if (start_reg >= ppsp_pkg::SEC32_LIMIT) begin
                    status_next = ppsp_pkg::ST_OVERFLOW;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_DIV_S;
                end
            end
            S_DIV_S, S_DIV_P, S_DIV_Q: begin
                // five-step split: estimate, sum, back-multiply, remainder, fix-up
                sp_ph_next = sp_ph_reg + 3'd1;
                case (sp_ph_reg)
                    3'd0: sp_p_next = 61'(split_src[61:30]) * 61'(ppsp_pkg::SPLIT_RECIP);
                    3'd1: sp_q_next = sp_q_sum[31:0];
                    3'd2: sp_m_next = 62'(sp_q_reg) * 62'(ppsp_pkg::NS_PER_SEC[29:0]);
                    3'd3: sp_r_next = sp_diff[31:0];
                    default: begin
                        sp_ph_next = '0;
                        if (state_reg == S_DIV_S) begin
                            ssec_next  = sp_q_fix;
                            ssub_next  = sp_r_fix;
                            state_next = S_DIV_P;
                        end else if (state_reg == S_DIV_P) begin
                            psec_next  = sp_q_fix;
                            psub_next  = sp_r_fix;
                            state_next = S_DIV_Q;
                        end else begin
                            wsec_next  = sp_q_fix;
                            wsub_next  = sp_r_fix;
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_DONE: begin
                // hand the beat to the result register once it is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_ssec_next    = ok ? ssec_reg : '0;
                    o_ssub_next    = ok ? ssub_reg : '0;
                    o_psec_next    = ok ? psec_reg : '0;
                    o_psub_next    = ok ? psub_reg : '0;
                    o_wsec_next    = ok ? wsec_reg : '0;
                    o_wsub_next    = ok ? wsub_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sp_ph_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
            sp_ph_reg     <= sp_ph_next;
        end
        req_reg      <= req_next;
        status_reg   <= status_next;
        start_reg    <= start_next;
        rem_reg      <= rem_next;
        ssec_reg     <= ssec_next;
        ssub_reg     <= ssub_next;
        psec_reg     <= psec_next;
        psub_reg     <= psub_next;
        wsec_reg     <= wsec_next;
        wsub_reg     <= wsub_next;
        sp_p_reg     <= sp_p_next;
        sp_q_reg     <= sp_q_next;
        sp_m_reg     <= sp_m_next;
        sp_r_reg     <= sp_r_next;
        o_status_reg <= o_status_next;
        o_ssec_reg   <= o_ssec_next;
        o_ssub_reg   <= o_ssub_next;
        o_psec_reg   <= o_psec_next;
        o_psub_reg   <= o_psub_next;
        o_wsec_reg   <= o_wsec_next;
        o_wsub_reg   <= o_wsub_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_status            = o_status_reg;
    assign m_start_sec_out     = o_ssec_reg;
    assign m_start_subsec_out  = o_ssub_reg;
    assign m_period_sec_out    = o_psec_reg;
    assign m_period_subsec_out = o_psub_reg;
    assign m_pulse_sec_out     = o_wsec_reg;
    assign m_pulse_subsec_out  = o_wsub_reg;

endmodule

### hw/rtl/periodic_pulse_start_planner.sv
`timescale 1ns / 1ps
// top level of the periodic pulse start planner
// depends on ppsp_pkg, ppsp_front, ppsp_queue, ppsp_back
//
// usage:
//   s_* channel (valid/ready) carries one set-up request per beat; m_* channel
//   (valid/ready) returns exactly one result beat per request, in order.
//   cfg_we/cfg_wdata write start_guard_ns; write it only while the block is idle.
// operation:
//   the front classifies a request in the cycle it is accepted and pushes it into
//   a two-entry queue. the back runs one bit-serial divider for the period remainder
//   of relative-mode requests (launch, 64 steps, capture) and splits start, period
//   and pulse into seconds with a reciprocal multiply each. it takes the next request
//   from the queue only once it has handed the last result to the output register.
// reset:
//   synchronous active-low aresetn empties the queue, idles the back, drops
//   m_valid and restores start_guard_ns to 1000000.
// receiver stall:
//   a finished result waits in the output register; the back may finish the next
//   request and wait behind it, and s_ready stays high until the queue is full.

module periodic_pulse_start_planner #(
    parameter int QUEUE_DEPTH = ppsp_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_current_time_ns,
    input  logic [63:0] s_period_ns,
    input  logic [63:0] s_pulse_ns,
    input  logic [63:0] s_phase_ns,
    input  logic        s_enable_request,
    input  logic        s_absolute_mode,
    input  logic [31:0] s_abs_start_sec,
    input  logic [31:0] s_abs_start_subsec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_start_sec_out,
    output logic [29:0] m_start_subsec_out,
    output logic [31:0] m_period_sec_out,
    output logic [29:0] m_period_subsec_out,
    output logic [31:0] m_pulse_sec_out,
    output logic [29:0] m_pulse_subsec_out
);

    logic [31:0]    guard_reg;
    ppsp_pkg::req_t entry;
    ppsp_pkg::req_t q_data;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           push;

    // guard register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg <= ppsp_pkg::GUARD_RESET;
        end else if (cfg_we) begin
            guard_reg <= cfg_wdata;
        end
    end

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    ppsp_front u_front (
        .current_time_ns  (s_current_time_ns),
        .period_ns        (s_period_ns),
        .pulse_ns         (s_pulse_ns),
        .phase_ns         (s_phase_ns),
        .enable_request   (s_enable_request),
        .absolute_mode    (s_absolute_mode),
        .abs_start_sec    (s_abs_start_sec),
        .abs_start_subsec (s_abs_start_subsec),
        .start_guard_ns   (guard_reg),
        .entry            (entry)
    );

    ppsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    ppsp_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_valid),
        .q_data              (q_data),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_start_sec_out     (m_start_sec_out),
        .m_start_subsec_out  (m_start_subsec_out),
        .m_period_sec_out    (m_period_sec_out),
        .m_period_subsec_out (m_period_subsec_out),
        .m_pulse_sec_out     (m_pulse_sec_out),
        .m_pulse_subsec_out  (m_pulse_subsec_out)
    );

endmodule

### hw/rtl/ppsp_checker.sv
`timescale 1ns / 1ps
// port-level checker for the periodic pulse start planner, bound to the top
// depends on ppsp_pkg

module ppsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_start_sec_out,
    input logic [29:0] m_start_subsec_out,
    input logic [31:0] m_period_sec_out,
    input logic [29:0] m_period_subsec_out,
    input logic [31:0] m_pulse_sec_out,
    input logic [29:0] m_pulse_subsec_out
);

    // no result beat in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // a stalled result beat stays valid with its status and start seconds unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_start_sec_out))
        else $error("stalled result beat changed");

    // rejected requests carry zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ppsp_pkg::ST_OK) |->
        (m_start_sec_out == '0) && (m_start_subsec_out == '0) &&
        (m_period_sec_out == '0) && (m_period_subsec_out == '0) &&
        (m_pulse_sec_out == '0) && (m_pulse_subsec_out == '0))
        else $error("nonzero fields on rejected request");

    // sub-second parts stay below one second
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_start_subsec_out < 30'd1000000000) &&
        (m_period_subsec_out < 30'd1000000000) && (m_pulse_subsec_out < 30'd1000000000))
        else $error("sub-second field out of range");

endmodule

bind periodic_pulse_start_planner ppsp_checker u_ppsp_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_status            (m_status),
    .m_start_sec_out     (m_start_sec_out),
    .m_start_subsec_out  (m_start_subsec_out),
    .m_period_sec_out    (m_period_sec_out),
    .m_period_subsec_out (m_period_subsec_out),
    .m_pulse_sec_out     (m_pulse_sec_out),
    .m_pulse_subsec_out  (m_pulse_subsec_out)
);

### tb/sv/tb_periodic_pulse_start_planner.sv
`timescale 1ns / 1ps
// testbench for the periodic pulse start planner: directed and random set-up requests
// checked beat by beat against a local start-time predictor; depends on ppsp_pkg and the rtl

module tb_periodic_pulse_start_planner;

    localparam logic [63:0] NS1E9 = 64'd1000000000;
    localparam logic [63:0] U64MAX = 64'hffffffffffffffff;

    typedef struct {
        logic [63:0] now, period, pulse, phase;
        logic        enable, absolute;
        logic [31:0] abs_sec, abs_sub;
    } request_t;

    typedef struct {
        ppsp_pkg::status_t status;
        logic [31:0] start_sec;
        logic [29:0] start_sub;
        logic [31:0] period_sec;
        logic [29:0] period_sub;
        logic [31:0] pulse_sec;
        logic [29:0] pulse_sub;
    } plan_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_we = 0;
    logic [31:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [63:0] s_current_time_ns = '0, s_period_ns = '0, s_pulse_ns = '0, s_phase_ns = '0;
    logic s_enable_request = 0, s_absolute_mode = 0;
    logic [31:0] s_abs_start_sec = '0, s_abs_start_subsec = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [1:0] m_status;
    logic [31:0] m_start_sec_out, m_period_sec_out, m_pulse_sec_out;
    logic [29:0] m_start_subsec_out, m_period_subsec_out, m_pulse_subsec_out;

    logic [31:0] guard_ns;
    plan_t       expected_plans[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0, recv_stall_pct = 0;

    periodic_pulse_start_planner dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // start-time plan for one request under the current guard
    function automatic plan_t plan_start(request_t r);
        plan_t p;
        logic [63:0] earliest, start, rem;
        logic update;
        p = '{ppsp_pkg::ST_OK, 0, 0, 0, 0, 0, 0};
        update = r.absolute || r.enable || r.period != 0 || r.pulse != 0 || r.phase != 0;
        if (r.absolute && (r.abs_sub >= NS1E9 || r.phase != 0)) begin
            p.status = ppsp_pkg::ST_INVALID; return p;
        end
        if (!update) begin
            p.status = ppsp_pkg::ST_NO_UPDATE; return p;
        end
        if (r.period < 2 || r.pulse == 0 || r.pulse >= r.period
            || (!r.absolute && r.phase >= r.period) || r.period / NS1E9 > 64'hffffffff) begin
            p.status = ppsp_pkg::ST_INVALID; return p;
        end
        if (U64MAX - r.now < {32'd0, guard_ns}) begin
            p.status = ppsp_pkg::ST_OVERFLOW; return p;
        end
        earliest = r.now + {32'd0, guard_ns};
        if (r.absolute) begin
            start = {32'd0, r.abs_sec} * NS1E9 + {32'd0, r.abs_sub};
            if (start <= earliest) begin
                p.status = ppsp_pkg::ST_INVALID; return p;
            end
        end else begin
            rem = earliest % r.period;
            start = earliest - rem;
            if (rem != 0) begin
                if (U64MAX - start < r.period) begin
                    p.status = ppsp_pkg::ST_OVERFLOW; return p;
                end
                start += r.period;
            end
            if (U64MAX - start < r.phase) begin
                p.status = ppsp_pkg::ST_OVERFLOW; return p;
            end
            start += r.phase;
            if (start <= earliest) begin
                if (U64MAX - start < r.period) begin
                    p.status = ppsp_pkg::ST_OVERFLOW; return p;
                end
                start += r.period;
            end
        end
        if (start / NS1E9 > 64'hffffffff) begin
            p.status = ppsp_pkg::ST_OVERFLOW; return p;
        end
        p.start_sec = 32'(start / NS1E9);
        p.start_sub = 30'(start % NS1E9);
        p.period_sec = 32'(r.period / NS1E9);
        p.period_sub = 30'(r.period % NS1E9);
        p.pulse_sec = 32'(r.pulse / NS1E9);
        p.pulse_sub = 30'(r.pulse % NS1E9);
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h want %0h", what, got, want);
        mismatch_count++;
    endtask

    // send one request beat with random idle ahead of it
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_current_time_ns <= r.now;
        s_period_ns <= r.period;
        s_pulse_ns <= r.pulse;
        s_phase_ns <= r.phase;
        s_enable_request <= r.enable;
        s_absolute_mode <= r.absolute;
        s_abs_start_sec <= r.abs_sec;
        s_abs_start_subsec <= r.abs_sub;
        s_valid <= 1;
        expected_plans.push_back(plan_start(r));
        do @(posedge aclk); while (!s_ready);
    endtask

    // receiver stalls and result check
    always @(posedge aclk) begin
        plan_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_plans.size() == 0) begin
                report_mismatch("unexpected beat", m_status, 0);
            end else begin
                e = expected_plans.pop_front();
                if (m_status != e.status) report_mismatch("status", m_status, e.status);
                if (m_start_sec_out != e.start_sec)
                    report_mismatch("start_sec", m_start_sec_out, e.start_sec);
                if (m_start_subsec_out != e.start_sub)
                    report_mismatch("start_subsec", m_start_subsec_out, e.start_sub);
                if (m_period_sec_out != e.period_sec)
                    report_mismatch("period_sec", m_period_sec_out, e.period_sec);
                if (m_period_subsec_out != e.period_sub)
                    report_mismatch("period_subsec", m_period_subsec_out, e.period_sub);
                if (m_pulse_sec_out != e.pulse_sec)
                    report_mismatch("pulse_sec", m_pulse_sec_out, e.pulse_sec);
                if (m_pulse_subsec_out != e.pulse_sub)
                    report_mismatch("pulse_subsec", m_pulse_subsec_out, e.pulse_sub);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic drain;
        s_valid <= 0;
        while (expected_plans.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_guard(logic [31:0] value);
        drain();
        cfg_we <= 1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 0;
        guard_ns = value;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly well-formed requests with random content, some noise
    function automatic request_t random_request();
        request_t r;
        int kind;
        kind = $urandom_range(99);
        r.now = rand64();
        r.enable = 1'($urandom_range(1));
        r.absolute = 1'($urandom_range(1));
        r.abs_sec = $urandom();
        r.abs_sub = $urandom_range(999999999);
        case ($urandom_range(3))
            0: r.period = 64'($urandom_range(1000, 2));
            1: r.period = 64'($urandom()) * 64'($urandom_range(50, 1));
            2: r.period = rand64() >> $urandom_range(63, 20);
            default: r.period = rand64();
        endcase
        r.pulse = (r.period > 1) ? 64'd1 + rand64() % (r.period - 1) : 64'd1;
        r.phase = r.absolute ? 64'd0 : ((r.period != 0) ? rand64() % r.period : 64'd0);
        // keep now under the 32-bit second range most of the time
        if (kind < 75) r.now = rand64() % 64'd4294000000000000000;
        if (r.absolute && kind < 60) begin
            if (r.now < 64'd4294000000000000000) begin
                r.abs_sec = 32'((r.now + guard_ns) / NS1E9 + $urandom_range(3));
                r.abs_sub = $urandom_range(999999999);
            end
        end
        if (kind >= 85) begin
            r.period = rand64();
            r.pulse = rand64();
            r.phase = rand64();
            r.abs_sub = $urandom();
        end
        if (kind >= 97) begin
            r.period = '0; r.pulse = '0; r.phase = '0;
            r.absolute = 1'b0; r.enable = 1'b0;
        end
        return r;
    endfunction

    task automatic test_directed;
        request_t r;
        r = '{64'd5000000000, 64'd1000000000, 64'd500000000, 64'd0, 1, 0, 0, 0};
        send_request(r);
        r.phase = 64'd999999999; send_request(r);
        r.period = 64'd1; send_request(r);
        r.period = 64'd2; r.pulse = 64'd1; r.phase = 64'd1; send_request(r);
        r.pulse = 64'd0; send_request(r);
        r.pulse = 64'd2; send_request(r);
        r.period = 64'd100; r.pulse = 64'd10; r.phase = 64'd100; send_request(r);
        r = '{64'd0, 64'd0, 64'd0, 64'd0, 0, 0, 0, 0};
        send_request(r);
        r.enable = 1; send_request(r);
        r = '{64'd0, 64'd4294967296000000000, 64'd1, 64'd0, 0, 0, 0, 0};
        send_request(r);
        r.period = 64'd4294967295999999999; send_request(r);
        r.now = U64MAX; r.period = 64'd1000; send_request(r);
        r.now = 64'd4294967295000000000; r.period = 64'd3000000000; send_request(r);
        r.now = U64MAX - 64'd2000000; r.period = 64'd7; r.pulse = 64'd3; send_request(r);
        r = '{64'd1000000000, 64'd1000, 64'd1, 64'd0, 1, 1, 32'd2, 32'd0};
        send_request(r);
        r.abs_sub = 32'd999999999; send_request(r);
        r.abs_sub = 32'd1000000000; send_request(r);
        r.abs_sub = 32'hffffffff; send_request(r);
        r.abs_sub = 0; r.phase = 64'd1; send_request(r);
        r.phase = 0; r.abs_sec = 32'd1; r.abs_sub = 32'd1000000; send_request(r);
        r.abs_sub = 32'd1000001; send_request(r);
        r.abs_sec = 32'hffffffff; r.abs_sub = 32'd999999999; r.now = 0; send_request(r);
        r.period = U64MAX; r.pulse = U64MAX - 1; send_request(r);
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_request(random_request());
    endtask

    initial begin
        guard_ns = ppsp_pkg::GUARD_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        write_guard(32'd0);
        test_directed();
        write_guard(32'hffffffff);
        test_directed();
        test_random(200, 0, 0);
        write_guard($urandom());
        test_random(200, 46, 0);
        drain();
        test_random(200, 0, 46);
        write_guard(32'd1000000);
        test_random(280, 22, 22);
        drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
